// ===== src/udpfc_pkg.sv =====
package udpfc_pkg;

  localparam int ETH_HDR_LEN = 14;
  localparam int IP_MIN_HDR = 20;
  localparam int UDP_HDR_LEN = 8;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0] IP_VERSION4 = 4'd4;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [15:0] DHCP_SERVER_PORT = 16'd67;
  localparam logic [15:0] DHCP_CLIENT_PORT = 16'd68;
  localparam logic [15:0] TEXT_PORT_RESET = 16'd5000;

  // Fixed byte positions of the Ethernet and IPv4 header fields.
  localparam int POS_ETYPE_HI = 12;
  localparam int POS_ETYPE_LO = 13;
  localparam int POS_VER_IHL = 14;
  localparam int POS_TOTLEN_HI = 16;
  localparam int POS_TOTLEN_LO = 17;
  localparam int POS_PROTOCOL = 23;
  localparam int POS_SRC_IP0 = 26;
  localparam int POS_SRC_IP1 = 27;
  localparam int POS_SRC_IP2 = 28;
  localparam int POS_SRC_IP3 = 29;

  typedef enum logic [1:0] {
    KIND_DROP  = 2'd0,
    KIND_DHCP  = 2'd1,
    KIND_TEXT  = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    DROP_NONE      = 3'd0,
    DROP_RUNT      = 3'd1,
    DROP_ETHERTYPE = 3'd2,
    DROP_IP_SHORT  = 3'd3,
    DROP_IHL       = 3'd4,
    DROP_TOTAL_LEN = 3'd5,
    DROP_NOT_UDP   = 3'd6,
    DROP_OVERSIZE  = 3'd7
  } drop_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } udpfc_in_t;

  typedef struct packed {
    kind_e       kind;
    drop_e       drop_reason;
    logic [31:0] source_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [6:0]  payload_offset;
    logic [11:0] payload_length;
  } udpfc_out_t;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [7:0]  version_ihl;
    logic [15:0] ip_total_length;
    logic [7:0]  ip_protocol;
    logic [31:0] src_address;
    logic [15:0] udp_length;
    logic [15:0] udp_sport;
    logic [15:0] udp_dport;
  } udpfc_hdr_t;

endpackage

// ===== src/udpfc_classify.sv =====
module udpfc_classify #(
  parameter int MAX_FRAME_BYTES = 2048,
  parameter int CNT_W = 12
) (
  input  udpfc_pkg::udpfc_hdr_t hdr_i,
  input  logic [CNT_W-1:0]      len_i,
  input  logic [15:0]           text_port_i,
  output udpfc_pkg::udpfc_out_t res_o
);
  import udpfc_pkg::*;

  logic [16:0] len_w;
  logic [16:0] ihl_w;
  logic [16:0] tot_w;
  logic [16:0] ulen_w;
  logic [16:0] len_m_eth;
  logic [16:0] tot_c;
  logic [16:0] ulen_c;
  logic        oversize;
  drop_e       reason;
  kind_e       kind;

  always_comb begin
    len_w     = 17'(len_i);
    ihl_w     = 17'({hdr_i.version_ihl[3:0], 2'b00});
    tot_w     = 17'(hdr_i.ip_total_length);
    ulen_w    = 17'(hdr_i.udp_length);
    len_m_eth = len_w - 17'(ETH_HDR_LEN);
    oversize  = len_i > CNT_W'(MAX_FRAME_BYTES);

    // The IP total length may not run past the end of the frame.
    if (tot_w + 17'(ETH_HDR_LEN) > len_w) begin
      tot_c = len_m_eth;
    end else begin
      tot_c = tot_w;
    end

    if (oversize) begin
      reason = DROP_OVERSIZE;
    end else if (len_w < 17'(ETH_HDR_LEN)) begin
      reason = DROP_RUNT;
    end else if (hdr_i.ether_type != ETHERTYPE_IPV4) begin
      reason = DROP_ETHERTYPE;
    end else if (len_m_eth < 17'(IP_MIN_HDR) || hdr_i.version_ihl[7:4] != IP_VERSION4) begin
      reason = DROP_IP_SHORT;
    end else if (ihl_w < 17'(IP_MIN_HDR) || len_w < 17'(ETH_HDR_LEN) + ihl_w) begin
      reason = DROP_IHL;
    end else if (tot_w < ihl_w) begin
      reason = DROP_TOTAL_LEN;
    end else if (hdr_i.ip_protocol != PROTO_UDP || tot_c < ihl_w + 17'(UDP_HDR_LEN)) begin
      reason = DROP_NOT_UDP;
    end else begin
      reason = DROP_NONE;
    end

    // A UDP length that is too short or overruns the datagram is replaced
    // by what the IP header leaves for it.
    if (ulen_w < 17'(UDP_HDR_LEN) || ihl_w + ulen_w > tot_c) begin
      ulen_c = tot_c - ihl_w;
    end else begin
      ulen_c = ulen_w;
    end

    if (hdr_i.udp_sport == DHCP_SERVER_PORT && hdr_i.udp_dport == DHCP_CLIENT_PORT) begin
      kind = KIND_DHCP;
    end else if (hdr_i.udp_dport == text_port_i) begin
      kind = KIND_TEXT;
    end else begin
      kind = KIND_OTHER;
    end

    res_o = '0;
    res_o.kind = KIND_DROP;
    res_o.drop_reason = reason;
    if (reason == DROP_NONE) begin
      res_o.kind           = kind;
      res_o.source_ip      = hdr_i.src_address;
      res_o.source_port    = hdr_i.udp_sport;
      res_o.dest_port      = hdr_i.udp_dport;
      res_o.payload_offset = 7'(ETH_HDR_LEN + UDP_HDR_LEN) + 7'(ihl_w[5:0]);
      res_o.payload_length = 12'(ulen_c - 17'(UDP_HDR_LEN));
    end
  end

endmodule

// ===== src/udp_frame_classifier.sv =====
// Ethernet / IPv4 / UDP receive header classifier.
//
// The input channel carries one frame byte per request together with a
// last-byte flag. Header fields are captured as their bytes go by; on the
// last byte of a frame the block emits one descriptor on the output
// channel with the verdict, drop reason, source address and ports, and the
// payload offset and length. Bytes other than the last produce nothing.
//
// One byte is accepted per cycle while in_stall_o is low, frame after
// frame with no gap. The edge that accepts the last byte loads the
// frame snapshot register; the descriptor then moves on into the output
// register. The classification checks sit between those two registers.
//
// When the receiver stalls, the output register holds its descriptor and
// the snapshot register holds the next one; the input is stalled only when
// both are full and the output cannot move. The user must write the text
// port register through cfg_we_i / cfg_wdata_i only while no frame is in
// flight; the block does not enforce this. Reset clears the byte counter,
// captured headers and both valid flags, and loads the text port with 5000.
module udp_frame_classifier #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  udpfc_pkg::udpfc_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output udpfc_pkg::udpfc_out_t out_data_o,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i
);
  import udpfc_pkg::*;

  // The counter saturates at MAX_FRAME_BYTES + 1.
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  udpfc_hdr_t       hdr_q, hdr_d, hdr_cap;
  logic [15:0]      text_port_q;

  udpfc_hdr_t       snap_hdr_q;
  logic [CNT_W-1:0] snap_len_q;
  logic             snap_vld_q, snap_vld_d;

  udpfc_out_t       out_q, res;
  logic             out_vld_q, out_vld_d;

  logic             out_rdy, snap_adv, snap_free, in_acc, cap_en;
  logic [CNT_W-1:0] pos, udp_base;
  logic [7:0]       b;

  assign out_rdy    = !out_vld_q || !out_stall_i;
  assign snap_adv   = snap_vld_q && out_rdy;
  assign snap_free  = !snap_vld_q || out_rdy;
  assign in_stall_o = !snap_free;
  assign in_acc     = in_valid_i && snap_free;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    pos      = cnt_q;
    b        = in_data_i.frame_byte;
    cap_en   = in_acc && (cnt_q <= CNT_W'(MAX_FRAME_BYTES));
    udp_base = CNT_W'(ETH_HDR_LEN) + CNT_W'({hdr_q.version_ihl[3:0], 2'b00});
    hdr_cap  = hdr_q;
    cnt_inc  = cnt_q;

    if (cap_en) begin
      cnt_inc = cnt_q + CNT_W'(1);
      if (pos == CNT_W'(POS_ETYPE_HI))  hdr_cap.ether_type[15:8]      = b;
      if (pos == CNT_W'(POS_ETYPE_LO))  hdr_cap.ether_type[7:0]       = b;
      if (pos == CNT_W'(POS_VER_IHL))   hdr_cap.version_ihl           = b;
      if (pos == CNT_W'(POS_TOTLEN_HI)) hdr_cap.ip_total_length[15:8] = b;
      if (pos == CNT_W'(POS_TOTLEN_LO)) hdr_cap.ip_total_length[7:0]  = b;
      if (pos == CNT_W'(POS_PROTOCOL))  hdr_cap.ip_protocol           = b;
      if (pos == CNT_W'(POS_SRC_IP0))   hdr_cap.src_address[31:24]    = b;
      if (pos == CNT_W'(POS_SRC_IP1))   hdr_cap.src_address[23:16]    = b;
      if (pos == CNT_W'(POS_SRC_IP2))   hdr_cap.src_address[15:8]     = b;
      if (pos == CNT_W'(POS_SRC_IP3))   hdr_cap.src_address[7:0]      = b;
      // UDP header positions follow the IHL captured earlier in the frame.
      if (pos > CNT_W'(POS_VER_IHL)) begin
        if (pos == udp_base)                hdr_cap.udp_sport[15:8]  = b;
        if (pos == udp_base + CNT_W'(1))    hdr_cap.udp_sport[7:0]   = b;
        if (pos == udp_base + CNT_W'(2))    hdr_cap.udp_dport[15:8]  = b;
        if (pos == udp_base + CNT_W'(3))    hdr_cap.udp_dport[7:0]   = b;
        if (pos == udp_base + CNT_W'(4))    hdr_cap.udp_length[15:8] = b;
        if (pos == udp_base + CNT_W'(5))    hdr_cap.udp_length[7:0]  = b;
      end
    end

    if (in_acc && in_data_i.last_byte) begin
      cnt_d = '0;
      hdr_d = '0;
    end else begin
      cnt_d = cnt_inc;
      hdr_d = hdr_cap;
    end

    if (in_acc && in_data_i.last_byte) begin
      snap_vld_d = 1'b1;
    end else if (snap_adv) begin
      snap_vld_d = 1'b0;
    end else begin
      snap_vld_d = snap_vld_q;
    end

    if (snap_adv) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  udpfc_classify #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .CNT_W(CNT_W)
  ) u_classify (
    .hdr_i(snap_hdr_q),
    .len_i(snap_len_q),
    .text_port_i(text_port_q),
    .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      hdr_q       <= '0;
      snap_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      text_port_q <= TEXT_PORT_RESET;
    end else begin
      cnt_q      <= cnt_d;
      hdr_q      <= hdr_d;
      snap_vld_q <= snap_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        text_port_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.last_byte) begin
      snap_hdr_q <= hdr_cap;
      snap_len_q <= cnt_inc;
    end
    if (snap_adv) begin
      out_q <= res;
    end
  end

endmodule

// ===== src/udpfc_checker.sv =====
module udpfc_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_stall_i,
  input udpfc_pkg::udpfc_out_t out_data_i
);
  import udpfc_pkg::*;

  // A stalled descriptor stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled descriptor changed");

  // A dropped frame carries a reason and no header or payload fields.
  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind == KIND_DROP |->
      out_data_i.drop_reason != DROP_NONE && out_data_i.source_ip == '0 &&
      out_data_i.source_port == '0 && out_data_i.dest_port == '0 &&
      out_data_i.payload_offset == '0 && out_data_i.payload_length == '0)
    else $error("dropped descriptor is not clean");

  // Accepted frames have no reason and a payload offset of 22 plus whole words.
  a_pass_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind != KIND_DROP |->
      out_data_i.drop_reason == DROP_NONE && out_data_i.payload_offset >= 7'd42 &&
      out_data_i.payload_offset[1:0] == 2'b10)
    else $error("accepted descriptor has a bad reason or offset");

  a_dhcp_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind == KIND_DHCP |->
      out_data_i.source_port == DHCP_SERVER_PORT &&
      out_data_i.dest_port == DHCP_CLIENT_PORT)
    else $error("DHCP verdict with wrong ports");

endmodule

bind udp_frame_classifier udpfc_checker u_udpfc_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_i(out_data_o)
);
